FILE: src/i8080_pkg.sv
package i8080_pkg;

	localparam int unsigned MEM_ADDR_BITS = 16;
	localparam int unsigned MEM_DEPTH = 1 << MEM_ADDR_BITS;

	localparam int unsigned IN_DATA_BITS = 32;
	localparam int unsigned OUT_DATA_BITS = 72;
	localparam int unsigned CMD_BITS = 2;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	// command codes
	localparam logic [CMD_BITS-1:0] CMD_EXEC = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_LOAD = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_READ = 2'd2;

	// opcodes decoded by exact match
	localparam logic [7:0] OPC_NOP   = 8'h00;
	localparam logic [7:0] OPC_HLT   = 8'h76;
	localparam logic [7:0] OPC_SUB_B = 8'h90;

	// operand codes: 0 B, 1 C, 2 D, 3 E, 4 H, 5 L, 6 M, 7 A
	localparam logic [2:0] CODE_B = 3'd0;
	localparam logic [2:0] CODE_M = 3'd6;
	localparam logic [2:0] CODE_A = 3'd7;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_MOV,
		OP_ADD,
		OP_ADC,
		OP_SUB,
		OP_LOAD,
		OP_READ,
		OP_UNSUP
	} op_kind_t;

	// classified item handed from the front end to the back end
	typedef struct packed {
		op_kind_t                 kind;
		logic [2:0]               dst;
		logic [2:0]               src;
		logic                     use_hl;
		logic [MEM_ADDR_BITS-1:0] addr;
		logic [7:0]               data;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

FILE: src/i8080_ram.sv
module i8080_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256,
	parameter int unsigned ADDR_BITS = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_BITS-1:0] waddr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 re,
	input  logic [ADDR_BITS-1:0] raddr,
	output logic [WIDTH-1:0]     rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/i8080_front.sv
module i8080_front (
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [i8080_pkg::IN_DATA_BITS-1:0]    s_tdata,
	input  logic [i8080_pkg::CMD_BITS-1:0]        s_tuser,
	input  i8080_pkg::queue_status_t              q_status,
	output logic                                  q_push,
	output i8080_pkg::item_t                      q_item
);
	import i8080_pkg::*;

	logic [7:0]  opcode;
	logic [15:0] load_address;
	logic [7:0]  load_byte;

	assign opcode       = s_tdata[7:0];
	assign load_address = s_tdata[23:8];
	assign load_byte    = s_tdata[31:24];

	assign s_tready = ~q_status.full;
	assign q_push   = s_tvalid & ~q_status.full;

	// classify the command and opcode into a back-end operation
	always_comb begin
		q_item.kind   = OP_NOP;
		q_item.dst    = opcode[5:3];
		q_item.src    = opcode[2:0];
		q_item.use_hl = 1'b1;
		q_item.addr   = load_address[MEM_ADDR_BITS-1:0];
		q_item.data   = load_byte;
		case (s_tuser)
			CMD_EXEC: begin
				if (opcode == OPC_NOP || opcode == OPC_HLT) begin
					q_item.kind = OP_NOP;
				end else if (opcode[7:6] == 2'b01) begin
					q_item.kind = OP_MOV;
				end else if (opcode[7:4] == 4'h8) begin
					q_item.kind = opcode[3] ? OP_ADC : OP_ADD;
				end else if (opcode == OPC_SUB_B) begin
					q_item.kind = OP_SUB;
					q_item.src  = CODE_B;
				end else begin
					q_item.kind = OP_UNSUP;
				end
			end
			CMD_LOAD: begin
				q_item.kind   = OP_LOAD;
				q_item.use_hl = 1'b0;
			end
			CMD_READ: begin
				q_item.kind   = OP_READ;
				q_item.use_hl = 1'b0;
			end
			default: begin
				q_item.kind = OP_NOP;
			end
		endcase
	end

endmodule

FILE: src/i8080_fifo.sv
module i8080_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  i8080_pkg::item_t         push_item,
	input  logic                     pop,
	output i8080_pkg::item_t         head_item,
	output i8080_pkg::queue_status_t status
);
	import i8080_pkg::*;

	item_t                     slot_q [0:QUEUE_DEPTH-1];
	logic [QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [QUEUE_CNT_BITS-1:0] count_q;
	logic                      do_push;
	logic                      do_pop;

	assign status.full  = (count_q == QUEUE_CNT_BITS'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push & ~status.full;
	assign do_pop       = pop & ~status.empty;
	assign head_item    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/i8080_back.sv
module i8080_back (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  i8080_pkg::item_t                       head_item,
	input  i8080_pkg::queue_status_t               q_status,
	output logic                                   q_pop,
	output logic                                   ram_we,
	output logic [i8080_pkg::MEM_ADDR_BITS-1:0]    ram_waddr,
	output logic [7:0]                             ram_wdata,
	output logic                                   ram_re,
	output logic [i8080_pkg::MEM_ADDR_BITS-1:0]    ram_raddr,
	input  logic [7:0]                             ram_rdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [i8080_pkg::OUT_DATA_BITS-1:0]    m_tdata,
	output logic                                   m_tuser
);
	import i8080_pkg::*;

	localparam int unsigned NUM_REGS = 7;
	localparam logic [2:0] IDX_H = 3'd4;
	localparam logic [2:0] IDX_L = 3'd5;
	localparam logic [2:0] IDX_A = 3'd6;

	typedef enum logic {
		PH_ADDR,
		PH_EXEC
	} phase_t;

	// register file slot for an operand code other than M
	function automatic logic [2:0] reg_idx(input logic [2:0] code);
		reg_idx = (code == CODE_A) ? IDX_A : code;
	endfunction

	function automatic logic [7:0] result_flags(input logic [7:0] r, input logic c);
		result_flags = {r[7], (r == 8'h00), 3'b000, ~^r, 1'b0, c};
	endfunction

	phase_t     phase_q;
	logic [7:0] rf_q [0:NUM_REGS-1];
	logic [7:0] rf_d [0:NUM_REGS-1];
	logic [7:0] flags_q;
	logic [7:0] flags_d;
	logic       out_valid_q;
	logic [OUT_DATA_BITS-1:0] out_data_q;
	logic       out_unsup_q;

	logic [15:0]              hl;
	logic [MEM_ADDR_BITS-1:0] mem_addr;
	logic [7:0]               operand;
	logic [7:0]               acc;
	logic                     cin;
	logic [8:0]               sum9;
	logic [8:0]               diff9;
	logic                     exec_fire;
	logic [7:0]               rd_byte;

	assign hl       = {rf_q[IDX_H], rf_q[IDX_L]};
	assign mem_addr = head_item.use_hl ? hl[MEM_ADDR_BITS-1:0] : head_item.addr;
	assign acc      = rf_q[IDX_A];
	assign operand  = (head_item.src == CODE_M) ? ram_rdata : rf_q[reg_idx(head_item.src)];
	assign cin      = (head_item.kind == OP_ADC) ? flags_q[0] : 1'b0;
	assign sum9     = {1'b0, acc} + {1'b0, operand} + {8'h00, cin};
	assign diff9    = {1'b0, acc} - {1'b0, operand};

	// first phase: read memory at the item address; second: update and emit
	assign ram_re    = (phase_q == PH_ADDR) & ~q_status.empty;
	assign ram_raddr = mem_addr;
	assign exec_fire = (phase_q == PH_EXEC) & (~out_valid_q | m_tready);
	assign q_pop     = exec_fire;

	assign ram_we    = exec_fire & ((head_item.kind == OP_LOAD) |
		((head_item.kind == OP_MOV) & (head_item.dst == CODE_M)));
	assign ram_waddr = mem_addr;
	assign ram_wdata = (head_item.kind == OP_LOAD) ? head_item.data : operand;

	assign rd_byte = (head_item.kind == OP_READ) ? ram_rdata : 8'h00;

	always_comb begin
		rf_d    = rf_q;
		flags_d = flags_q;
		case (head_item.kind)
			OP_MOV: begin
				if (head_item.dst != CODE_M) begin
					rf_d[reg_idx(head_item.dst)] = operand;
				end
			end
			OP_ADD, OP_ADC: begin
				rf_d[IDX_A] = sum9[7:0];
				flags_d     = result_flags(sum9[7:0], sum9[8]);
			end
			OP_SUB: begin
				rf_d[IDX_A] = diff9[7:0];
				flags_d     = result_flags(diff9[7:0], diff9[8]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ADDR;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			out_unsup_q <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) begin
				rf_q[i] <= '0;
			end
		end else begin
			if (exec_fire) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (phase_q)
				PH_ADDR: begin
					if (!q_status.empty) begin
						phase_q <= PH_EXEC;
					end
				end
				PH_EXEC: begin
					if (exec_fire) begin
						phase_q     <= PH_ADDR;
						rf_q        <= rf_d;
						flags_q     <= flags_d;
						out_unsup_q <= (head_item.kind == OP_UNSUP);
						out_data_q  <= {rd_byte, flags_d, rf_d[IDX_L], rf_d[IDX_H],
							rf_d[3], rf_d[2], rf_d[1], rf_d[0], rf_d[IDX_A]};
					end
				end
				default: begin
					phase_q <= PH_ADDR;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_unsup_q;

endmodule

FILE: src/i8080_mov_alu_execute.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_tvalid/s_tready  s_tuser command; s_tdata opcode, load_address, load_byte
// m_        out  m_tvalid/m_tready  m_tdata registers, flags, read_byte; m_tuser unsupported
//
// Each item passes the back end's address phase, a registered memory read at HL
// or load_address, then its execute phase: the register, flag and memory update.
// A two-entry queue parts the decoding front end from the back end, and the
// result sits in an output register, so input is taken while a result waits.
// arst_n clears the registers, flags, queue and output valid; memory is not cleared.
// A stalled m_tready holds the back end in its update phase with the read data kept.
module i8080_mov_alu_execute (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [7:0] opcode, [23:8] load_address, [31:24] load_byte
	input  logic [31:0] s_tdata,
	// [1:0] command
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] reg_a, [15:8] reg_b, [23:16] reg_c, [31:24] reg_d, [39:32] reg_e,
	// [47:40] reg_h, [55:48] reg_l, [63:56] flag_byte, [71:64] read_byte
	output logic [71:0] m_tdata,
	// [0] unsupported
	output logic        m_tuser
);
	import i8080_pkg::*;

	item_t                    push_item;
	item_t                    head_item;
	queue_status_t            q_status;
	logic                     q_push;
	logic                     q_pop;
	logic                     ram_we;
	logic [MEM_ADDR_BITS-1:0] ram_waddr;
	logic [7:0]               ram_wdata;
	logic                     ram_re;
	logic [MEM_ADDR_BITS-1:0] ram_raddr;
	logic [7:0]               ram_rdata;

	// decode and push into the queue
	i8080_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_status (q_status),
		.q_push   (q_push),
		.q_item   (push_item)
	);

	i8080_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.pop       (q_pop),
		.head_item (head_item),
		.status    (q_status)
	);

	// execute in order against the register file and memory
	i8080_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_item (head_item),
		.q_status  (q_status),
		.q_pop     (q_pop),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	i8080_ram #(
		.WIDTH     (8),
		.DEPTH     (MEM_DEPTH),
		.ADDR_BITS (MEM_ADDR_BITS)
	) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

FILE: tb/i8080_exec_sb_pkg.sv
package i8080_exec_sb_pkg;

	import i8080_pkg::*;

	// operand codes not named in the design package
	localparam logic [2:0] CODE_C = 3'd1;
	localparam logic [2:0] CODE_D = 3'd2;
	localparam logic [2:0] CODE_E = 3'd3;
	localparam logic [2:0] CODE_H = 3'd4;
	localparam logic [2:0] CODE_L = 3'd5;

	// opcode ranges
	localparam logic [7:0] OPC_MOV_LO = 8'h40;
	localparam logic [7:0] OPC_MOV_HI = 8'h7F;
	localparam logic [7:0] OPC_ADD_LO = 8'h80;
	localparam logic [7:0] OPC_ADC_LO = 8'h88;
	localparam logic [7:0] OPC_ADC_HI = 8'h8F;

	localparam logic [7:0] FLAG_S = 8'h80;
	localparam logic [7:0] FLAG_Z = 8'h40;
	localparam logic [7:0] FLAG_P = 8'h04;
	localparam logic [7:0] FLAG_C = 8'h01;

	localparam int unsigned SHOW_LIMIT = 10;

	typedef struct packed {
		logic [71:0] data;
		logic        unsup;
	} cpu_snapshot_t;

	class exec_scoreboard;
		// indexed by operand code; the CODE_M slot is unused
		logic [7:0]               regs [8];
		logic [7:0]               flags;
		logic [7:0]               mem [MEM_DEPTH];
		bit                       written [MEM_DEPTH];
		logic [MEM_ADDR_BITS-1:0] written_list [$];
		cpu_snapshot_t            snapshot_q [$];
		int unsigned              mismatches, unexpected, checked;
		int unsigned              loads, reads, execs, unsup_count;

		function new();
			foreach (regs[i]) regs[i] = 8'h00;
			flags = 8'h00;
			mismatches = 0;
			unexpected = 0;
			checked = 0;
			loads = 0;
			reads = 0;
			execs = 0;
			unsup_count = 0;
		endfunction

		function int unsigned pending();
			return snapshot_q.size();
		endfunction

		function logic [MEM_ADDR_BITS-1:0] hl();
			logic [15:0] pair;
			pair = {regs[CODE_H], regs[CODE_L]};
			return pair[MEM_ADDR_BITS-1:0];
		endfunction

		function logic [7:0] operand(logic [2:0] code);
			if (code == CODE_M)
				return mem[hl()];
			return regs[code];
		endfunction

		function void mark_written(logic [MEM_ADDR_BITS-1:0] at);
			if (!written[at]) begin
				written[at] = 1'b1;
				written_list.push_back(at);
			end
		endfunction

		function void store(logic [2:0] code, logic [7:0] v);
			if (code == CODE_M) begin
				mem[hl()] = v;
				mark_written(hl());
			end else begin
				regs[code] = v;
			end
		endfunction

		function void set_flags(logic [7:0] r, logic carry);
			flags = flags & ~(FLAG_S | FLAG_Z | FLAG_P | FLAG_C);
			if (r[7])
				flags = flags | FLAG_S;
			if (r == 8'h00)
				flags = flags | FLAG_Z;
			if (~^r)
				flags = flags | FLAG_P;
			if (carry)
				flags = flags | FLAG_C;
		endfunction

		// true when the item would fetch a memory byte that was never written
		function bit reads_unwritten(logic [1:0] cmd, logic [7:0] op, logic [15:0] addr,
				output logic [MEM_ADDR_BITS-1:0] at);
			at = addr[MEM_ADDR_BITS-1:0];
			if (cmd == CMD_READ)
				return !written[at];
			if (cmd != CMD_EXEC || op == OPC_HLT)
				return 1'b0;
			at = hl();
			if (op >= OPC_MOV_LO && op <= OPC_ADC_HI && op[2:0] == CODE_M)
				return !written[at];
			return 1'b0;
		endfunction

		function void note_item(logic [1:0] cmd, logic [7:0] op, logic [15:0] addr,
				logic [7:0] data);
			logic [MEM_ADDR_BITS-1:0] at;
			logic [8:0]               sum;
			logic [7:0]               rd, a, b;
			logic                     unsup;
			cpu_snapshot_t            snap;
			at = addr[MEM_ADDR_BITS-1:0];
			rd = 8'h00;
			unsup = 1'b0;
			case (cmd)
				CMD_EXEC: begin
					execs++;
					if (op == OPC_NOP || op == OPC_HLT) begin
						// no state change
					end else if (op >= OPC_MOV_LO && op <= OPC_MOV_HI) begin
						store(op[5:3], operand(op[2:0]));
					end else if (op >= OPC_ADD_LO && op <= OPC_ADC_HI) begin
						sum = {1'b0, regs[CODE_A]} + {1'b0, operand(op[2:0])}
							+ ((op >= OPC_ADC_LO && (flags & FLAG_C) != 8'h00) ? 9'd1 : 9'd0);
						regs[CODE_A] = sum[7:0];
						set_flags(sum[7:0], sum[8]);
					end else if (op == OPC_SUB_B) begin
						a = regs[CODE_A];
						b = regs[CODE_B];
						regs[CODE_A] = a - b;
						set_flags(regs[CODE_A], a < b);
					end else begin
						unsup = 1'b1;
						unsup_count++;
					end
				end
				CMD_LOAD: begin
					loads++;
					mem[at] = data;
					mark_written(at);
				end
				CMD_READ: begin
					reads++;
					rd = mem[at];
				end
				default: begin
				end
			endcase
			snap.data = {rd, flags, regs[CODE_L], regs[CODE_H], regs[CODE_E], regs[CODE_D],
				regs[CODE_C], regs[CODE_B], regs[CODE_A]};
			snap.unsup = unsup;
			snapshot_q.push_back(snap);
		endfunction

		function void report(string name, logic [7:0] want, logic [7:0] got);
			mismatches++;
			if (mismatches <= SHOW_LIMIT)
				$display("mismatch on result %0d, %s: expected %02h, got %02h",
					checked, name, want, got);
		endfunction

		function void check_result(logic [71:0] data, logic unsup);
			string         names [9];
			cpu_snapshot_t want;
			names = '{"reg_a", "reg_b", "reg_c", "reg_d", "reg_e", "reg_h", "reg_l",
				"flag_byte", "read_byte"};
			if (snapshot_q.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= SHOW_LIMIT)
					$display("result with nothing expected: tdata %018h tuser %b", data, unsup);
				return;
			end
			want = snapshot_q.pop_front();
			checked++;
			for (int i = 0; i < 9; i++)
				if (data[8*i +: 8] !== want.data[8*i +: 8])
					report(names[i], want.data[8*i +: 8], data[8*i +: 8]);
			if (unsup !== want.unsup)
				report("unsupported", {7'd0, want.unsup}, {7'd0, unsup});
		endfunction
	endclass

endpackage

FILE: tb/i8080_mov_alu_execute_test.sv
module i8080_mov_alu_execute_test;

	timeunit 1ns;
	timeprecision 1ps;

	import i8080_pkg::*;
	import i8080_exec_sb_pkg::*;

	// command code the block must treat as a do-nothing
	localparam logic [CMD_BITS-1:0] CMD_IDLE = 2'd3;

	localparam int unsigned RANDOM_ITEMS = 950;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 20;

	// a spread of opcodes outside the implemented set
	localparam logic [7:0] UNSUP_SAMPLES [5] = '{8'hFF, 8'h01, 8'h91, 8'hC3, 8'h3F};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic        m_tuser;

	exec_scoreboard sb;
	int unsigned    cycles = 0;
	// when set, that side runs flat out with no idle cycles
	bit             src_calm = 1'b0;
	bit             sink_calm = 1'b0;

	i8080_mov_alu_execute i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	// abandon a run that has hung
	initial begin
		wait (cycles > CYCLE_LIMIT);
		$display("cycle limit of %0d reached", CYCLE_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int unsigned draw_gap(bit calm);
		return calm ? 0 : $urandom_range(0, 5);
	endfunction

	function automatic logic [7:0] mov_op(logic [2:0] dst, logic [2:0] src);
		return {2'b01, dst, src};
	endfunction

	// ADD (carry_in clear) or ADC (carry_in set) with source operand src
	function automatic logic [7:0] alu_op(logic carry_in, logic [2:0] src);
		return {4'b1000, carry_in, src};
	endfunction

	// bias addresses towards both ends of memory so that hits are frequent
	function automatic logic [15:0] pick_address();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 15));
			1: return 16'hFFF0 | 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	// weight towards implemented opcodes, with a tail of arbitrary bytes
	function automatic logic [7:0] pick_opcode();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return OPC_MOV_LO + 8'($urandom_range(0, 63));
		if (r < 75)
			return OPC_ADD_LO + 8'($urandom_range(0, 15));
		if (r < 83)
			return OPC_SUB_B;
		if (r < 88)
			return $urandom_range(0, 1) ? OPC_NOP : OPC_HLT;
		return 8'($urandom);
	endfunction

	// Present one item and hold it until taken. A zero gap keeps tvalid high
	// straight into the next item.
	task automatic send_item(logic [1:0] cmd, logic [7:0] op, logic [15:0] addr,
			logic [7:0] data);
		int unsigned gap;
		gap = draw_gap(src_calm);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tuser <= cmd;
		s_tdata <= {data, addr, op};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (s_tready !== 1'b1);
		sb.note_item(cmd, op, addr, data);
	endtask

	// Precede any item that would fetch never-written memory with a load of
	// that byte, so only defined contents are ever read back.
	task automatic issue(logic [1:0] cmd, logic [7:0] op, logic [15:0] addr,
			logic [7:0] data);
		logic [MEM_ADDR_BITS-1:0] at;
		logic [15:0]              wide;
		if (sb.reads_unwritten(cmd, op, addr, at)) begin
			wide = 16'($urandom);
			wide[MEM_ADDR_BITS-1:0] = at;
			send_item(CMD_LOAD, 8'($urandom), wide, 8'($urandom));
		end
		send_item(cmd, op, addr, data);
	endtask

	task automatic exec(logic [7:0] op);
		issue(CMD_EXEC, op, 16'($urandom), 8'($urandom));
	endtask

	// Drain results: unless the sink is calm, stall tready for a random gap before
	// each one, then take it and check it against the oldest prediction.
	initial begin : result_sink
		int unsigned gap;
		wait (arst_n === 1'b1);
		forever begin
			gap = draw_gap(sink_calm);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			sb.check_result(m_tdata, m_tuser);
			if ($urandom_range(0, 63) == 0)
				sink_calm = !sink_calm;
		end
	end

	initial begin : stimulus
		int unsigned      r;
		logic [15:0]      addr;
		logic [7:0]       op;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: memory at both ends, with all-ones and all-zero bytes
		issue(CMD_LOAD, 8'h00, 16'h0000, 8'hFF);
		issue(CMD_LOAD, 8'hFF, 16'hFFFF, 8'h00);
		issue(CMD_READ, 8'($urandom), 16'h0000, 8'($urandom));
		issue(CMD_READ, 8'($urandom), 16'hFFFF, 8'($urandom));
		// HL is zero after reset, so M is the byte just loaded at the bottom
		exec(mov_op(CODE_A, CODE_M));
		exec(mov_op(CODE_B, CODE_A));
		// carry out, carry in and borrow, all from all-ones operands
		exec(alu_op(1'b0, CODE_B));
		exec(alu_op(1'b1, CODE_B));
		exec(OPC_SUB_B);
		exec(OPC_NOP);
		exec(OPC_HLT);
		// point HL at the top of memory, then use M as source and destination
		exec(mov_op(CODE_H, CODE_B));
		exec(mov_op(CODE_L, CODE_B));
		exec(alu_op(1'b0, CODE_M));
		exec(alu_op(1'b1, CODE_M));
		exec(mov_op(CODE_M, CODE_A));
		exec(mov_op(CODE_C, CODE_M));
		// a zero result: Z and even parity set, no borrow
		exec(mov_op(CODE_A, CODE_B));
		exec(OPC_SUB_B);
		exec(alu_op(1'b0, CODE_A));
		exec(mov_op(CODE_D, CODE_C));
		exec(mov_op(CODE_E, CODE_D));
		foreach (UNSUP_SAMPLES[i])
			exec(UNSUP_SAMPLES[i]);
		// the spare command code leaves everything alone
		issue(CMD_IDLE, 8'($urandom), 16'($urandom), 8'($urandom));

		// random: mostly register traffic and arithmetic, with loads and reads
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 20) begin
				issue(CMD_LOAD, 8'($urandom), pick_address(), 8'($urandom));
			end else if (r < 32) begin
				if (sb.written_list.size() != 0 && $urandom_range(0, 9) < 7) begin
					addr = 16'($urandom);
					addr[MEM_ADDR_BITS-1:0] =
						sb.written_list[$urandom_range(0, sb.written_list.size() - 1)];
				end else begin
					addr = pick_address();
				end
				issue(CMD_READ, 8'($urandom), addr, 8'($urandom));
			end else if (r < 98) begin
				op = pick_opcode();
				exec(op);
			end else begin
				issue(CMD_IDLE, 8'($urandom), 16'($urandom), 8'($urandom));
			end
			if ($urandom_range(0, 63) == 0)
				src_calm = !src_calm;
		end
		s_tvalid <= 1'b0;

		// drop nothing: wait for every prediction to be checked, then idle a little
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d results: %0d loads, %0d reads, %0d executes (%0d unsupported)",
			sb.checked, sb.loads, sb.reads, sb.execs, sb.unsup_count);
		$display("%0d distinct memory bytes written, %0d field mismatches, %0d stray results",
			sb.written_list.size(), sb.mismatches, sb.unexpected);
		if (sb.mismatches == 0 && sb.unexpected == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: files.f
src/i8080_pkg.sv
src/i8080_ram.sv
src/i8080_front.sv
src/i8080_fifo.sv
src/i8080_back.sv
src/i8080_mov_alu_execute.sv
tb/i8080_exec_sb_pkg.sv
tb/i8080_mov_alu_execute_test.sv
